>>> design/gss_pkg.sv
// Package for the grid step sequencer.
// Holds the transfer payload types, operation codes and register map.
// No dependencies.
package gss_pkg;

    localparam int ADDR_W = 3;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_GRID  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam logic [ADDR_W-1:0] REG_ARMED = 3'd0;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] grid_row;
        logic [3:0] grid_step;
        logic       grid_value;
    } gss_in_t;

    typedef struct packed {
        logic [6:0] note_number;
        logic       note_on;
        logic       last;
    } gss_out_t;

    typedef struct packed {
        logic load;
        logic note_on;
        logic tail;
    } gss_scan_ld_t;

    typedef struct packed {
        logic fire;
        logic note_on;
        logic last;
        logic done;
    } gss_scan_ev_t;

endpackage

>>> design/grid_step_sequencer.sv
// Grid step sequencer top level: command port, APB register, sequencer.
// Instantiates gss_grid and gss_scan; uses gss_pkg.
//
// A tick while running keeps busy high through the registered grid read and
// while the single row scanner walks every row once for note-offs and once
// for note-ons, one row per cycle. A stop while running keeps busy high for a
// note-off pass and a grid write for a read and a write; after a start or any
// ignored command busy stays low. Each event appears on result for one cycle
// under strobe, in the cycle after the scanner visits its row; the receiver
// cannot stall it, so no events are held back or dropped while armed is set.
module grid_step_sequencer
    import gss_pkg::*;
#(
    parameter int NUM_ROWS  = 12,
    parameter int NUM_STEPS = 16,
    parameter int BASE_NOTE = 60
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gss_in_t           cmd,
    output logic              strobe,
    output gss_out_t          result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SW = $clog2(NUM_STEPS);
    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WREAD,
        ST_WWRITE,
        ST_OFFS,
        ST_ONS
    } state_t;

    state_t              state_reg, state_next;
    logic                running_reg, running_next;
    logic [SW-1:0]       step_reg, step_next;
    logic [NUM_ROWS-1:0] sounding_reg, sounding_next;
    logic [NUM_ROWS-1:0] column_reg, column_next;
    logic [RW-1:0]       wrow_reg, wrow_next;
    logic                wval_reg, wval_next;
    logic [SW-1:0]       waddr_reg, waddr_next;
    logic                tick_reg, tick_next;
    logic                armed_reg, armed_next;
    logic                strobe_reg, strobe_next;
    gss_out_t            result_reg, result_next;

    logic                accept;
    logic                cfg_write;
    logic                grid_we;
    logic [NUM_ROWS-1:0] grid_wdata;
    logic [SW-1:0]       grid_raddr;
    logic [NUM_ROWS-1:0] grid_rdata;
    logic [NUM_ROWS-1:0] row_bit;
    gss_scan_ld_t        scan_ld;
    logic [NUM_ROWS-1:0] scan_mask;
    gss_scan_ev_t        scan_ev;
    logic [RW-1:0]       scan_row;
    logic                scan_active;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr == REG_ARMED) ? {31'd0, armed_reg} : 32'd0;

    assign grid_raddr = (state_reg != ST_IDLE)       ? waddr_reg :
                        (cmd.operation == OP_TICK) ? step_reg  : SW'(cmd.grid_step);
    assign row_bit    = NUM_ROWS'(1) << wrow_reg;
    assign grid_we    = (state_reg == ST_WWRITE);
    assign grid_wdata = wval_reg ? (grid_rdata | row_bit) : (grid_rdata & ~row_bit);

    gss_grid #(
        .NUM_ROWS  (NUM_ROWS),
        .NUM_STEPS (NUM_STEPS),
        .SW        (SW)
    ) u_grid (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (grid_we),
        .waddr (waddr_reg),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    gss_scan #(
        .NUM_ROWS (NUM_ROWS),
        .RW       (RW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ld      (scan_ld),
        .mask    (scan_mask),
        .emit_en (armed_reg),
        .ev      (scan_ev),
        .row     (scan_row),
        .active  (scan_active)
    );

    always_comb
    begin
        state_next    = state_reg;
        running_next  = running_reg;
        step_next     = step_reg;
        sounding_next = sounding_reg;
        column_next   = column_reg;
        wrow_next     = wrow_reg;
        wval_next     = wval_reg;
        waddr_next    = waddr_reg;
        tick_next     = tick_reg;
        armed_next    = cfg_write && (paddr == REG_ARMED) ? pwdata[0] : armed_reg;
        scan_ld       = '0;
        scan_mask     = sounding_reg;

        strobe_next              = scan_ev.fire;
        result_next.note_number  = 7'(BASE_NOTE) + 7'(scan_row);
        result_next.note_on      = scan_ev.note_on;
        result_next.last         = scan_ev.last;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        OP_TICK:
                        begin
                            if (running_reg)
                            begin
                                tick_next  = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        OP_GRID:
                        begin
                            if ((32'(cmd.grid_row) < NUM_ROWS) &&
                                (32'(cmd.grid_step) < NUM_STEPS))
                            begin
                                wrow_next  = RW'(cmd.grid_row);
                                wval_next  = cmd.grid_value;
                                waddr_next = SW'(cmd.grid_step);
                                state_next = ST_WREAD;
                            end
                        end
                        OP_START:
                        begin
                            if (!running_reg && armed_reg)
                            begin
                                running_next = 1'b1;
                                step_next    = '0;
                            end
                        end
                        OP_STOP:
                        begin
                            if (running_reg)
                            begin
                                running_next  = 1'b0;
                                tick_next     = 1'b0;
                                sounding_next = '0;
                                scan_ld.load  = 1'b1;
                                state_next    = ST_OFFS;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                column_next   = grid_rdata;
                sounding_next = grid_rdata;
                step_next     = (step_reg == SW'(NUM_STEPS - 1)) ? '0 : step_reg + SW'(1);
                scan_ld.load  = 1'b1;
                scan_ld.tail  = (grid_rdata != '0);
                state_next    = ST_OFFS;
            end
            ST_WREAD:
            begin
                state_next = ST_WWRITE;
            end
            ST_WWRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_OFFS:
            begin
                if (scan_ev.done)
                begin
                    if (tick_reg)
                    begin
                        scan_ld.load    = 1'b1;
                        scan_ld.note_on = 1'b1;
                        scan_mask       = column_reg;
                        state_next      = ST_ONS;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ONS:
            begin
                scan_mask = column_reg;
                if (scan_ev.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            running_reg  <= 1'b0;
            step_reg     <= '0;
            sounding_reg <= '0;
            tick_reg     <= 1'b0;
            armed_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            step_reg     <= step_next;
            sounding_reg <= sounding_next;
            tick_reg     <= tick_next;
            armed_reg    <= armed_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        column_reg <= column_next;
        wrow_reg   <= wrow_next;
        wval_reg   <= wval_next;
        waddr_reg  <= waddr_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_idle_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !scan_active)
        else $error("row scanner active while sequencer idle");

    a_ons_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ONS) |-> running_reg)
        else $error("note-on pass while stopped");

    a_more_events_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !result_reg.last) |-> busy)
        else $error("transfer not last but sequencer idle");

    a_start_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(running_reg) |-> (step_reg == '0))
        else $error("start did not clear step");

endmodule

>>> design/gss_grid.sv
// Pattern grid store: one word of row bits per step, registered read.
// Per-step valid flags give cleared contents after reset. Uses gss_pkg.
module gss_grid
    import gss_pkg::*;
#(
    parameter int NUM_ROWS  = 12,
    parameter int NUM_STEPS = 16,
    parameter int SW        = $clog2(NUM_STEPS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                we,
    input  logic [SW-1:0]       waddr,
    input  logic [NUM_ROWS-1:0] wdata,
    input  logic [SW-1:0]       raddr,
    output logic [NUM_ROWS-1:0] rdata
);

    logic [NUM_ROWS-1:0]  mem [NUM_STEPS];
    logic [NUM_STEPS-1:0] valid_reg;
    logic [NUM_ROWS-1:0]  rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

>>> design/gss_scan.sv
// Row scanner: walks a row mask one row per cycle and flags each set row while emit_en is high.
// Shared by note-off and note-on passes. Uses gss_pkg.
module gss_scan
    import gss_pkg::*;
#(
    parameter int NUM_ROWS = 12,
    parameter int RW       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  gss_scan_ld_t        ld,
    input  logic [NUM_ROWS-1:0] mask,
    input  logic                emit_en,
    output gss_scan_ev_t        ev,
    output logic [RW-1:0]       row,
    output logic                active
);

    logic [NUM_ROWS-1:0] sr_reg;
    logic [RW-1:0]       cnt_reg;
    logic                active_reg;
    logic                tail_reg;
    logic                on_reg;
    logic                end_row;

    assign end_row = active_reg && (cnt_reg == RW'(NUM_ROWS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (ld.load)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            active_reg <= !end_row;
            cnt_reg    <= cnt_reg + RW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            sr_reg   <= mask;
            tail_reg <= ld.tail;
            on_reg   <= ld.note_on;
        end
        else if (active_reg)
        begin
            sr_reg <= sr_reg >> 1;
        end
    end

    assign ev.fire    = active_reg && sr_reg[0] && emit_en;
    assign ev.note_on = on_reg;
    assign ev.last    = !tail_reg && ((sr_reg >> 1) == '0);
    assign ev.done    = end_row;
    assign row        = cnt_reg;
    assign active     = active_reg;

endmodule

>>> tb/tb.sv
// Testbench for grid_step_sequencer: command transfers, note events and the armed register.
// Predicts every note event from its own copy of the grid and sequencer state.
// Depends on gss_pkg and the grid_step_sequencer design sources.
module tb
    import gss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS          = 12;
    localparam int STEPS         = 16;
    localparam int BASE          = 60;
    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 1000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    gss_in_t           cmd;
    logic              strobe;
    gss_out_t          result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    logic [ROWS-1:0] grid_model [STEPS];
    logic [3:0]      step_pos;
    logic [ROWS-1:0] sounding;
    logic            running_model;
    logic            armed_model;
    gss_out_t        note_batch[$];
    gss_out_t        pending_events[$];
    int              errors = 0;
    int              stall_cycles = 0;
    bit              quiet = 1'b0;

    grid_step_sequencer #(
        .NUM_ROWS  (ROWS),
        .NUM_STEPS (STEPS),
        .BASE_NOTE (BASE)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .strobe  (strobe),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void add_note(int row, logic on);
        gss_out_t ev;
        ev.note_number = 7'(BASE + row);
        ev.note_on     = on;
        ev.last        = 1'b0;
        if (armed_model)
            note_batch = {note_batch, ev};
    endfunction

    function automatic void release_rows();
        for (int r = 0; r < ROWS; r++)
            if (sounding[r])
                add_note(r, 1'b0);
        sounding = '0;
    endfunction

    function automatic void predict_events(gss_in_t c);
        note_batch.delete();
        case (c.operation)
            OP_TICK:
                if (running_model)
                begin
                    release_rows();
                    for (int r = 0; r < ROWS; r++)
                        if (grid_model[step_pos][r])
                            add_note(r, 1'b1);
                    sounding = grid_model[step_pos];
                    step_pos = 4'((int'(step_pos) + 1) % STEPS);
                end
            OP_GRID:
                if (c.grid_row < ROWS && c.grid_step < STEPS)
                    grid_model[c.grid_step][c.grid_row] = c.grid_value;
            OP_START:
                if (!running_model && armed_model)
                begin
                    running_model = 1'b1;
                    step_pos = '0;
                end
            OP_STOP:
                if (running_model)
                begin
                    running_model = 1'b0;
                    release_rows();
                end
            default:
                ;
        endcase
        for (int i = 0; i < note_batch.size(); i++)
        begin
            gss_out_t ev;
            ev = note_batch[i];
            ev.last = (i == note_batch.size() - 1);
            pending_events = {pending_events, ev};
        end
    endfunction

    function automatic gss_in_t make_cmd(logic [1:0] op);
        gss_in_t c;
        c.operation  = op;
        c.grid_row   = 4'($urandom_range(0, 15));
        c.grid_step  = 4'($urandom_range(0, 15));
        c.grid_value = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic send_cmd(gss_in_t c);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_events(c);
    endtask

    task automatic write_cell(int row, int column, logic v);
        gss_in_t c;
        c = make_cmd(OP_GRID);
        c.grid_row   = 4'(row);
        c.grid_step  = 4'(column);
        c.grid_value = v;
        send_cmd(c);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_armed(logic v);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ARMED;
        pwdata  <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        armed_model = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {31'b0, v})
        begin
            $display("%0t: armed readback mismatch, expected %h, got %h",
                     $time, {31'b0, v}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_stopped_commands();
        send_cmd(make_cmd(OP_START));
        send_cmd(make_cmd(OP_TICK));
        send_cmd(make_cmd(OP_STOP));
        write_cell(15, 15, 1'b1);
        write_cell(12, 0, 1'b1);
    endtask

    task automatic test_pattern_playback();
        set_armed(1'b1);
        write_cell(0, 0, 1'b1);
        write_cell(11, 0, 1'b1);
        write_cell(5, 1, 1'b1);
        write_cell(11, 1, 1'b1);
        write_cell(7, 15, 1'b1);
        send_cmd(make_cmd(OP_START));
        send_cmd(make_cmd(OP_TICK));
        send_cmd(make_cmd(OP_START));
        send_cmd(make_cmd(OP_TICK));
        write_cell(11, 1, 1'b0);
        send_cmd(make_cmd(OP_STOP));
        send_cmd(make_cmd(OP_STOP));
        send_cmd(make_cmd(OP_TICK));
    endtask

    task automatic test_suppressed_tracking();
        send_cmd(make_cmd(OP_START));
        set_armed(1'b0);
        send_cmd(make_cmd(OP_TICK));
        set_armed(1'b1);
        send_cmd(make_cmd(OP_TICK));
        set_armed(1'b0);
        send_cmd(make_cmd(OP_STOP));
        set_armed(1'b1);
        send_cmd(make_cmd(OP_START));
        send_cmd(make_cmd(OP_TICK));
        send_cmd(make_cmd(OP_STOP));
    endtask

    task automatic run_pattern(bit fill);
        int      base_col;
        int      n_ticks;
        gss_in_t c;
        if (fill)
        begin
            base_col = $urandom_range(0, STEPS - 2);
            for (int s = 0; s < 2; s++)
                for (int r = 0; r < ROWS; r++)
                    write_cell(r, base_col + s, 1'b1);
            n_ticks = STEPS + 4;
        end
        else
        begin
            repeat ($urandom_range(3, 8))
            begin
                c = make_cmd(OP_GRID);
                c.grid_row   = 4'($urandom_range(0, ROWS - 1));
                c.grid_value = ($urandom_range(0, 2) != 0);
                send_cmd(c);
            end
            n_ticks = $urandom_range(8, 20);
        end
        send_cmd(make_cmd(OP_START));
        repeat (n_ticks)
        begin
            if ($urandom_range(0, 5) == 0)
                send_cmd(make_cmd(2'($urandom_range(0, 3))));
            else
                send_cmd(make_cmd(OP_TICK));
        end
        send_cmd(make_cmd(OP_STOP));
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 8; ph++)
        begin
            set_armed((ph == 3) ? 1'b0 : (ph < 3) ? 1'b1 : 1'($urandom_range(0, 3) != 0));
            quiet = (ph >= 6);
            run_pattern(ph == 0);
        end
    endtask

    always @(posedge clk)
    begin
        gss_out_t want;
        if (rst_n && strobe)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected note event, expected none, %s %0d on %b last %b",
                         $time, "got note", result.note_number, result.note_on,
                         result.last);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (result.note_number !== want.note_number || result.note_on !== want.note_on
                    || result.last !== want.last)
                begin
                    $display("%0t: note mismatch, expected note %0d on %b last %b, %s",
                             $time, want.note_number, want.note_on, want.last, "got");
                    $display("%0t:     got note %0d on %b last %b",
                             $time, result.note_number, result.note_on, result.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        cmd     <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        for (int s = 0; s < STEPS; s++)
            grid_model[s] = '0;
        step_pos      = '0;
        sounding      = '0;
        running_model = 1'b0;
        armed_model   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stopped_commands();
        test_pattern_playback();
        test_suppressed_tracking();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
